// ===== rtl/rac_pkg.sv =====
`default_nettype none

package rac_pkg;

  // Default receive buffer depth in bytes; the byte counter saturates here.
  localparam int RAC_MAX_FRAME = 4096;

  // Configuration port
  localparam int          CFG_ADDR_W        = 3;
  localparam int          CFG_DATA_W        = 32;
  localparam logic [2:0]  REG_PROTOCOL_MODE = 3'd0;

  // Protocol mode codes
  localparam logic [2:0] MODE_MODBUS = 3'd0;
  localparam logic [2:0] MODE_DNP3   = 3'd1;
  localparam logic [2:0] MODE_S7COMM = 3'd2;
  localparam logic [2:0] MODE_IEC104 = 3'd3;
  localparam logic [2:0] MODE_OPCUA  = 3'd4;

  // Checked byte positions
  localparam int POS_MODBUS_EXC = 7;
  localparam int POS_DNP3_IIN   = 10;
  localparam int POS_S7_CLASS   = 5;
  localparam int POS_IEC_CTRL   = 2;
  localparam int PREFIX_MIN_LEN = 4;
  localparam int OVERSIZE_LEN   = 300;
  localparam int MARKER_MIN_POS = 3;

  localparam logic [7:0]  S7_ERR_CLASS = 8'hD0;
  localparam logic [7:0]  ASCII_E      = 8'h45;
  localparam logic [7:0]  ASCII_R      = 8'h52;
  localparam logic [31:0] MARKER_WORD  = 32'hBAADF00D;

  typedef enum logic [2:0] {
    VERDICT_NORMAL    = 3'd0,
    VERDICT_EXCEPTION = 3'd1,
    VERDICT_OVERSIZED = 3'd2,
    VERDICT_MARKER    = 3'd3,
    VERDICT_NORESP    = 3'd4
  } verdict_t;

  // Control for one processed transaction handed to the frame unit
  typedef struct packed {
    logic step;
    logic last;
    logic none;
  } frame_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/response_anomaly_classifier_top.sv =====
// Response anomaly classifier: takes a response frame one byte per input
// transaction and returns one verdict transaction when the frame ends (the
// byte with in_last_byte set, or any transaction with in_no_response set,
// which discards the frame so far and reports no-response). Throughput is one
// byte per clock while the result register can take a verdict; a final byte
// waits in the input register until it can. A verdict passes the input
// register, the combinational frame logic and then the result register. The
// result register lets new bytes keep flowing while a verdict waits to be taken.
// protocol_mode sits at byte address 0 of the APB-style port and should only
// be written between frames. Bytes past MAX_FRAME are ignored by all checks
// (the byte counter saturates there) but the final byte still closes the frame.
`default_nettype none

module response_anomaly_classifier_top
  import rac_pkg::*;
#(
  parameter int MAX_FRAME = RAC_MAX_FRAME
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // byte stream in
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [7:0]            in_data_byte,
  input  wire logic                  in_last_byte,
  input  wire logic                  in_no_response,
  // verdict out
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [2:0]                 out_verdict,
  // configuration
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0]      prdata,
  output logic                       pready
);

  // ---------------- configuration register ----------------
  logic [2:0] mode_r, mode_nxt;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    mode_nxt = mode_r;
    if (cfg_wr && (paddr == CFG_ADDR_W'(REG_PROTOCOL_MODE))) begin
      mode_nxt = pwdata[2:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == CFG_ADDR_W'(REG_PROTOCOL_MODE)) begin
      prdata = {{(CFG_DATA_W-3){1'b0}}, mode_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_MODBUS;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  // ---------------- input register ----------------
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       s1_none_r;
  logic       s1_has_result;
  logic       s1_adv;
  logic       out_free;
  logic       in_take;

  // s1 holds a transaction that ends a frame until the result register is free
  assign s1_has_result = s1_last_r || s1_none_r;
  assign out_free      = !out_valid || out_ready;
  assign s1_adv        = s1_valid_r && (!s1_has_result || out_free);
  assign in_ready      = !s1_valid_r || s1_adv;
  assign in_take       = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last_byte;
      s1_none_r <= in_no_response;
    end
  end

  // ---------------- frame logic ----------------
  frame_ctl_t ctl;
  verdict_t   verdict;

  assign ctl.step = s1_adv;
  assign ctl.last = s1_last_r;
  assign ctl.none = s1_none_r;

  rac_frame_unit #(
    .MAX_FRAME (MAX_FRAME)
  ) u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .data_byte (s1_byte_r),
    .mode      (mode_r),
    .verdict   (verdict)
  );

  // ---------------- result register ----------------
  logic       out_valid_r, out_valid_nxt;
  logic [2:0] out_verdict_r;
  logic       out_load;

  assign out_load = s1_adv && s1_has_result;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_verdict_r <= verdict;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_verdict = out_verdict_r;

endmodule

`default_nettype wire

// ===== rtl/rac_frame_unit.sv =====
`default_nettype none

module rac_frame_unit
  import rac_pkg::*;
#(
  parameter int MAX_FRAME = RAC_MAX_FRAME
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire frame_ctl_t ctl,
  input  wire logic [7:0] data_byte,
  input  wire logic [2:0] mode,
  output verdict_t        verdict
);

  localparam int CNT_W = $clog2(MAX_FRAME + 1);

  logic [CNT_W-1:0] count_r, count_nxt, count_new;
  logic [23:0]      recent_r, recent_nxt, recent_new;
  logic             hit_r, hit_nxt, hit_new;
  logic             prefix_r, prefix_nxt, prefix_new;
  logic             marker_r, marker_nxt, marker_new;

  logic        pos_ok;
  logic        hit_byte;
  logic        prefix_bad;
  logic [31:0] window;

  assign pos_ok = count_r < CNT_W'(MAX_FRAME);
  assign window = {recent_r, data_byte};

  always_comb begin
    case (mode)
      MODE_MODBUS: hit_byte = (count_r == CNT_W'(POS_MODBUS_EXC)) && data_byte[7];
      MODE_DNP3:   hit_byte = (count_r == CNT_W'(POS_DNP3_IIN)) && data_byte[6];
      MODE_S7COMM: hit_byte = (count_r == CNT_W'(POS_S7_CLASS)) && (data_byte == S7_ERR_CLASS);
      MODE_IEC104: hit_byte = (count_r == CNT_W'(POS_IEC_CTRL)) && data_byte[0];
      default:     hit_byte = 1'b0;
    endcase
  end

  assign prefix_bad = ((count_r == CNT_W'(0)) && (data_byte != ASCII_E)) ||
                      ((count_r == CNT_W'(1)) && (data_byte != ASCII_R)) ||
                      ((count_r == CNT_W'(2)) && (data_byte != ASCII_R));

  assign hit_new    = hit_r | (pos_ok & hit_byte);
  assign prefix_new = prefix_r & ~(pos_ok & prefix_bad);
  assign marker_new = marker_r |
                      (pos_ok && (count_r >= CNT_W'(MARKER_MIN_POS)) && (window == MARKER_WORD));
  assign recent_new = pos_ok ? window[23:0] : recent_r;
  assign count_new  = pos_ok ? count_r + CNT_W'(1) : count_r;

  // Verdict priority: empty, exception, oversize, marker, normal
  always_comb begin
    if (ctl.none) begin
      verdict = VERDICT_NORESP;
    end else if (hit_new) begin
      verdict = VERDICT_EXCEPTION;
    end else if ((mode == MODE_OPCUA) && prefix_new &&
                 (count_new >= CNT_W'(PREFIX_MIN_LEN))) begin
      verdict = VERDICT_EXCEPTION;
    end else if ((mode == MODE_MODBUS) && (count_new > CNT_W'(OVERSIZE_LEN))) begin
      verdict = VERDICT_OVERSIZED;
    end else if (marker_new) begin
      verdict = VERDICT_MARKER;
    end else begin
      verdict = VERDICT_NORMAL;
    end
  end

  always_comb begin
    count_nxt  = count_r;
    recent_nxt = recent_r;
    hit_nxt    = hit_r;
    prefix_nxt = prefix_r;
    marker_nxt = marker_r;
    if (ctl.step) begin
      if (ctl.none || ctl.last) begin
        count_nxt  = '0;
        recent_nxt = '0;
        hit_nxt    = 1'b0;
        prefix_nxt = 1'b1;
        marker_nxt = 1'b0;
      end else begin
        count_nxt  = count_new;
        recent_nxt = recent_new;
        hit_nxt    = hit_new;
        prefix_nxt = prefix_new;
        marker_nxt = marker_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      recent_r <= '0;
      hit_r    <= 1'b0;
      prefix_r <= 1'b1;
      marker_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      recent_r <= recent_nxt;
      hit_r    <= hit_nxt;
      prefix_r <= prefix_nxt;
      marker_r <= marker_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rac_checker.sv =====
`default_nettype none

module rac_checker
  import rac_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic                  in_no_response,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [2:0]            out_verdict,
  input wire logic                  psel,
  input wire logic                  penable,
  input wire logic                  pwrite,
  input wire logic [CFG_ADDR_W-1:0] paddr,
  input wire logic [CFG_DATA_W-1:0] pwdata,
  input wire logic [CFG_DATA_W-1:0] prdata
);

  // stalled verdict holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_verdict))
    else $error("verdict dropped or changed while stalled");

  // empty reception reports no-response through the input and result registers when the output is free
  a_noresp: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_no_response) ##1 (!out_valid || out_ready)
    |=> out_valid && (out_verdict == VERDICT_NORESP))
    else $error("no-response verdict missing");

  // mode write reads back
  a_cfg_rb: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && (paddr == CFG_ADDR_W'(REG_PROTOCOL_MODE))
    |=> prdata[2:0] == $past(pwdata[2:0]))
    else $error("protocol_mode readback mismatch");

  // nothing comes out right after reset
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("verdict valid after reset");

endmodule

bind response_anomaly_classifier_top rac_checker u_rac_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_no_response (in_no_response),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_verdict    (out_verdict),
  .psel           (psel),
  .penable        (penable),
  .pwrite         (pwrite),
  .paddr          (paddr),
  .pwdata         (pwdata),
  .prdata         (prdata)
);

`default_nettype wire

// ===== tb/sv/response_anomaly_classifier_top_test.sv =====
module response_anomaly_classifier_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rac_pkg::*;

  // Receive buffer depth; the byte counter saturates here.
  localparam int FRAME_CAP = RAC_MAX_FRAME;

  // Register map: protocol_mode is register 0, so byte address 0.
  localparam logic [CFG_ADDR_W-1:0] MODE_REG_ADDR = CFG_ADDR_W'(4 * REG_PROTOCOL_MODE);

  // Mode codes with no position check. 7 is the top of the register range.
  localparam logic [2:0] MODE_SPARE_LO = 3'd5;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  // Classification constants
  localparam int          MODBUS_EXC_POS = 7;
  localparam int          DNP3_IIN_POS   = 10;
  localparam int          S7_CLASS_POS   = 5;
  localparam int          IEC_CTRL_POS   = 2;
  localparam int          OVERSIZE_BYTES = 300;
  localparam logic [31:0] MARKER_PATTERN = 32'hBAADF00D;

  // Cycles to let the pipeline empty before a register write; the path holds
  // only the input reg and the result reg, so this leaves plenty of margin.
  localparam int SETTLE_CYCLES = 8;

  // Cycles with no accepted transaction on any port before the run is killed.
  // The longest legal quiet stretch is the output hold-off.
  localparam int WATCHDOG_LIMIT = 5000;

  typedef logic [7:0] byte_q_t[$];

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT signals. Every input is known from time zero.
  // ---------------------------------------------------------------------------
  logic                  clk            = 1'b0;
  logic                  rst_n          = 1'b0;
  logic                  in_valid       = 1'b0;
  logic                  in_ready;
  logic [7:0]            in_data_byte   = '0;
  logic                  in_last_byte   = 1'b0;
  logic                  in_no_response = 1'b0;
  logic                  out_valid;
  logic                  out_ready      = 1'b0;
  logic [2:0]            out_verdict;
  logic                  psel           = 1'b0;
  logic                  penable        = 1'b0;
  logic                  pwrite         = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr          = '0;
  logic [CFG_DATA_W-1:0] pwdata         = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  response_anomaly_classifier_top #(
    .MAX_FRAME(FRAME_CAP)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_byte  (in_data_byte),
    .in_last_byte  (in_last_byte),
    .in_no_response(in_no_response),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_verdict   (out_verdict),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // ---------------------------------------------------------------------------
  // Bookkeeping
  // ---------------------------------------------------------------------------
  int error_count      = 0;
  int bytes_sent       = 0;   // accepted input transactions
  int verdicts_checked = 0;   // accepted output transactions
  int hold_off_cycles  = 0;   // set by the hold-off test, consumed by the sink
  bit no_gaps          = 1'b0; // when set, neither side idles

  // Verdicts predicted but not yet returned, oldest first
  verdict_t pending_verdicts[$];

  // Frame state of the predictor
  logic [2:0]  mode_model;
  int          frame_len;     // saturates at FRAME_CAP
  logic [23:0] last_three;    // newest byte in the low bits
  bit          exc_hit;
  bit          err_prefix;
  bit          marker_hit;

  task automatic report_error(input string what);
    error_count++;
    $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  // Mostly back-to-back, some short pauses, a few long ones.
  function automatic int idle_len();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  task automatic restart_frame();
    frame_len  = 0;
    last_three = '0;
    exc_hit    = 1'b0;
    err_prefix = 1'b1;
    marker_hit = 1'b0;
  endtask

  // Updates the frame state for one accepted byte transaction and queues the
  // verdict when the frame closes.
  task automatic classify(input logic [7:0] b, input logic is_last, input logic is_empty);
    logic [31:0] window;
    verdict_t    v;
    // Empty reception throws away the partial frame.
    if (is_empty) begin
      restart_frame();
      pending_verdicts.push_back(VERDICT_NORESP);
      return;
    end
    // Bytes past the buffer depth are invisible to every check.
    if (frame_len < FRAME_CAP) begin
      // Position checks use the mode in force when the byte arrives.
      case (mode_model)
        MODE_MODBUS: if (frame_len == MODBUS_EXC_POS && b >= 8'h80) exc_hit = 1'b1;
        MODE_DNP3:   if (frame_len == DNP3_IIN_POS && b[6]) exc_hit = 1'b1;
        MODE_S7COMM: if (frame_len == S7_CLASS_POS && b == 8'hD0) exc_hit = 1'b1;
        MODE_IEC104: if (frame_len == IEC_CTRL_POS && b[0]) exc_hit = 1'b1;
        default: ;
      endcase
      if ((frame_len == 0 && b != 8'h45) || (frame_len == 1 && b != 8'h52) ||
          (frame_len == 2 && b != 8'h52))
        err_prefix = 1'b0;
      window = {last_three, b};
      if (frame_len >= 3 && window == MARKER_PATTERN) marker_hit = 1'b1;
      last_three = window[23:0];
      frame_len++;
    end
    if (is_last) begin
      // "ERR" prefix and oversize use the mode at the final byte.
      if (exc_hit)
        v = VERDICT_EXCEPTION;
      else if (mode_model == MODE_OPCUA && err_prefix && frame_len >= 4)
        v = VERDICT_EXCEPTION;
      else if (mode_model == MODE_MODBUS && frame_len > OVERSIZE_BYTES)
        v = VERDICT_OVERSIZED;
      else if (marker_hit)
        v = VERDICT_MARKER;
      else
        v = VERDICT_NORMAL;
      pending_verdicts.push_back(v);
      restart_frame();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driving side. All tasks start and end on a falling edge.
  // ---------------------------------------------------------------------------
  // One input transaction. Valid stays high on return so the next call can
  // offer back-to-back; whoever pauses must lower it first.
  task automatic send_byte(input logic [7:0] b, input logic is_last, input logic is_empty);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_data_byte   <= b;
    in_last_byte   <= is_last;
    in_no_response <= is_empty;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    classify(b, is_last, is_empty);
    @(negedge clk);
  endtask

  // Sends a byte sequence; close marks the final one as end of frame.
  task automatic send_bytes(input byte_q_t q, input bit close);
    foreach (q[i]) send_byte(q[i], close && (i == q.size() - 1), 1'b0);
  endtask

  function automatic byte_q_t fill_frame(input int len, input logic [7:0] value);
    byte_q_t q;
    repeat (len) q.push_back(value);
    return q;
  endfunction

  function automatic byte_q_t with_marker(input byte_q_t q, input int at);
    q[at]     = MARKER_PATTERN[31:24];
    q[at + 1] = MARKER_PATTERN[23:16];
    q[at + 2] = MARKER_PATTERN[15:8];
    q[at + 3] = MARKER_PATTERN[7:0];
    return q;
  endfunction

  // Drop valid, wait for every predicted verdict, then let the pipe drain.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One APB transfer: setup cycle, then access until pready.
  task automatic cfg_access(input bit is_write, input logic [CFG_DATA_W-1:0] wdata,
                            output logic [CFG_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= MODE_REG_ADDR;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_mode_reg();
    logic [CFG_DATA_W-1:0] rd;
    cfg_access(1'b0, '0, rd);
    if (rd !== CFG_DATA_W'(mode_model))
      report_error($sformatf("protocol_mode reads 0x%0h, expected 0x%0h", rd, mode_model));
  endtask

  // Mode writes happen only with the pipeline empty, possibly mid-frame.
  task automatic set_protocol_mode(input logic [2:0] mode);
    logic [CFG_DATA_W-1:0] unused_rd;
    settle();
    cfg_access(1'b1, CFG_DATA_W'(mode), unused_rd);
    mode_model = mode;
    // the bus idles before the readback
    @(negedge clk);
    check_mode_reg();
  endtask

  // ---------------------------------------------------------------------------
  // Result side: ready pattern, hold-off, and the checker
  // ---------------------------------------------------------------------------
  initial begin : verdict_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready  <= 1'b1;
        stall_left = idle_len();
      end
    end
  end

  // Every accepted verdict transaction must match the oldest prediction.
  always @(posedge clk) begin : verdict_check
    verdict_t want;
    if (rst_n && out_valid && out_ready) begin
      verdicts_checked++;
      if (pending_verdicts.size() == 0) begin
        report_error($sformatf("verdict %0d with no frame end pending", out_verdict));
      end else begin
        want = pending_verdicts.pop_front();
        if (out_verdict !== want)
          report_error($sformatf("verdict %0d, expected %0d (%s)",
                                 out_verdict, want, want.name()));
      end
    end
  end

  // Kill the run if no port moves a transaction for too long.
  always @(posedge clk) begin : watchdog
    int stuck_cycles;
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("TIMEOUT: no transaction for %0d cycles, %0d verdicts outstanding",
                 stuck_cycles, pending_verdicts.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // One hit per protocol mode, plus the modbus threshold and a short "ERR".
  task automatic test_position_checks();
    byte_q_t q;
    set_protocol_mode(MODE_MODBUS);
    q = fill_frame(8, 8'h00);
    q[MODBUS_EXC_POS] = 8'h80;             // exception code at threshold
    send_bytes(q, 1'b1);
    q[MODBUS_EXC_POS] = 8'h7F;             // just below
    send_bytes(q, 1'b1);
    set_protocol_mode(MODE_DNP3);
    q = fill_frame(11, 8'hBF);
    q[DNP3_IIN_POS] = 8'h40;
    send_bytes(q, 1'b1);
    set_protocol_mode(MODE_S7COMM);
    q = fill_frame(6, 8'hFF);
    q[S7_CLASS_POS] = 8'hD0;
    send_bytes(q, 1'b1);
    set_protocol_mode(MODE_IEC104);
    q = fill_frame(3, 8'hFE);
    q[IEC_CTRL_POS] = 8'h01;
    send_bytes(q, 1'b1);
    set_protocol_mode(MODE_OPCUA);
    q = '{8'h45, 8'h52, 8'h52, 8'hFF};     // "ERR" + one byte -> exception
    send_bytes(q, 1'b1);
    q = '{8'h45, 8'h52, 8'h52};            // "ERR" alone is too short
    send_bytes(q, 1'b1);
  endtask

  // Marker closing the frame, one-byte frames, empty reception alone and
  // after a partial frame.
  task automatic test_marker_and_empty();
    set_protocol_mode(MODE_SPARE_HI);
    send_bytes(with_marker(fill_frame(4, 8'h00), 0), 1'b1);
    send_byte(8'hFF, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b1);          // data and last ignored
    send_byte(8'h45, 1'b0, 1'b0);
    send_byte(8'h52, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b1);          // partial frame dropped
    send_byte(8'h00, 1'b1, 1'b0);
  endtask

  // Mode written between bytes of one frame.
  task automatic test_mode_change_in_frame();
    // hit latched under iec104 survives a switch to modbus
    set_protocol_mode(MODE_IEC104);
    send_bytes('{8'h10, 8'h20, 8'h01}, 1'b0);
    set_protocol_mode(MODE_MODBUS);
    send_bytes('{8'h00, 8'h00}, 1'b1);
    // "ERR" counted from the start even though opc ua is entered late
    send_bytes('{8'h45, 8'h52, 8'h52, 8'h00}, 1'b0);
    set_protocol_mode(MODE_OPCUA);
    send_byte(8'h00, 1'b1, 1'b0);
    // leaving opc ua before the final byte cancels the prefix verdict
    send_bytes('{8'h45, 8'h52, 8'h52, 8'h00}, 1'b0);
    set_protocol_mode(MODE_SPARE_HI);
    send_byte(8'h00, 1'b1, 1'b0);
  endtask

  // Oversize: one byte past the modbus limit.
  task automatic test_long_frames();
    set_protocol_mode(MODE_MODBUS);
    send_bytes(fill_frame(OVERSIZE_BYTES + 1, 8'h11), 1'b1);
  endtask

  // Sink holds off while the source keeps offering short frames back to back,
  // so the result register fills and in_ready has to drop.
  task automatic test_output_hold_off();
    set_protocol_mode(MODE_MODBUS);
    no_gaps         = 1'b1;
    hold_off_cycles = 300;
    repeat (20) begin
      send_byte(8'($urandom_range(255)), 1'b1, $urandom_range(7) == 0);
    end
    no_gaps = 1'b0;
  endtask

  // Random frames with biased content, per mode phase. Most are well formed;
  // the rest are lone empty receptions or truncated frames ended by an empty one.
  function automatic byte_q_t random_frame();
    byte_q_t q;
    int len, r;
    r = $urandom_range(99);
    if (r < 80) len = $urandom_range(12, 1);
    else        len = $urandom_range(20, 13);
    repeat (len) q.push_back(8'($urandom_range(255)));
    if (len > S7_CLASS_POS && $urandom_range(3) == 0) q[S7_CLASS_POS] = 8'hD0;
    if (len > 2 && $urandom_range(2) == 0) begin
      q[0] = 8'h45;
      q[1] = 8'h52;
      q[2] = 8'h52;
    end
    if (len >= 4 && $urandom_range(3) == 0) q = with_marker(q, $urandom_range(len - 4));
    return q;
  endfunction

  task automatic test_random_traffic();
    logic [2:0] phase_modes[8];
    byte_q_t    q;
    int         start, r;
    phase_modes = '{MODE_MODBUS, MODE_OPCUA, MODE_SPARE_HI, MODE_DNP3,
                    MODE_S7COMM, MODE_IEC104, MODE_SPARE_LO, 3'($urandom_range(7))};
    foreach (phase_modes[p]) begin
      set_protocol_mode(phase_modes[p]);
      no_gaps = ($urandom_range(3) == 0);
      start   = bytes_sent;
      while (bytes_sent - start < 6) begin
        r = $urandom_range(99);
        q = random_frame();
        if (r < 85) begin
          send_bytes(q, 1'b1);
        end else if (r < 93) begin
          send_byte(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
        end else begin
          repeat ($urandom_range(q.size() - 1)) void'(q.pop_back());
          send_bytes(q, 1'b0);
          send_byte(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
        end
      end
    end
    no_gaps = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    restart_frame();
    mode_model = MODE_MODBUS;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    check_mode_reg();                      // reset value of the mode
    test_position_checks();
    test_marker_and_empty();
    test_mode_change_in_frame();
    test_long_frames();
    test_output_hold_off();
    test_random_traffic();
    settle();

    if (pending_verdicts.size() != 0)
      report_error($sformatf("%0d verdicts never returned", pending_verdicts.size()));

    $display("Summary: %0d byte transactions, %0d verdicts checked, %0d mismatches",
             bytes_sent, verdicts_checked, error_count);
    $display("Summary: modes 0-7, mid-frame mode writes, an oversized frame, output hold-off");
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
